FILE: rtl/rbc_pkg.sv
// Package: shared types and codes for the reorder buffer commit block.
`default_nettype none
package rbc_pkg;

  // Kind of an issued entry
  typedef enum logic [2:0] {
    IK_NONE  = 3'd0,
    IK_REG   = 3'd1,
    IK_STORE = 3'd2,
    IK_BR_NT = 3'd3,
    IK_BR_T  = 3'd4,
    IK_JALR  = 3'd5,
    IK_OTHER = 3'd6
  } ikind_e;

  // Kind reported at commit
  typedef enum logic [2:0] {
    CK_REG    = 3'd0,
    CK_STORE  = 3'd1,
    CK_BRANCH = 3'd2,
    CK_JALR   = 3'd3,
    CK_OTHER  = 3'd4
  } ckind_e;

  // Fetch redirect codes
  typedef enum logic [1:0] {
    RD_NONE  = 2'd0,
    RD_FLUSH = 2'd1,
    RD_JALR  = 2'd2
  } redir_e;

  localparam logic [31:0] PcStep = 32'd4;

  typedef struct packed {
    logic [2:0]         issue_kind;
    logic               issue_ready;
    logic [4:0]         issue_dest;
    logic [31:0]        issue_pc;
    logic signed [31:0] issue_offset;
    logic               wb0_valid;
    logic [4:0]         wb0_index;
    logic signed [31:0] wb0_value;
    logic               wb1_valid;
    logic [4:0]         wb1_index;
    logic signed [31:0] wb1_value;
    logic               terminate;
  } in_item_t;

  typedef struct packed {
    logic               commit_valid;
    logic [2:0]         commit_kind;
    logic [4:0]         commit_dest;
    logic signed [31:0] reg_value;
    logic [4:0]         commit_index;
    logic               branch_taken;
    logic [1:0]         redirect;
    logic [31:0]        redirect_pc;
    logic               full_res;
    logic [4:0]         tail_slot;
    logic [4:0]         head_slot;
    logic               finish;
  } out_item_t;

  // Static fields of one queue slot
  typedef struct packed {
    logic [2:0]  kind;
    logic [4:0]  dest;
    logic [31:0] pc;
    logic [31:0] offset;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_ISSUE  = 3'd1,
    ST_WB0    = 3'd2,
    ST_WB1    = 3'd3,
    ST_READ   = 3'd4,
    ST_COMMIT = 3'd5
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic issue;
    logic wb0;
    logic wb1;
    logic read;
    logic commit;
  } rbc_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic frozen;
    logic out_free;
  } rbc_status_t;

endpackage
`default_nettype wire

FILE: rtl/rbc_if.sv
// Interfaces: valid/ready channels for input items and commit results.
`default_nettype none
interface rbc_in_if import rbc_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rbc_out_if import rbc_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/rbc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rbc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

FILE: rtl/rbc_ctrl.sv
// Controller: sequences issue, broadcasts, head read and commit of one item.
`default_nettype none
module rbc_ctrl import rbc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire rbc_status_t status_i,
  output rbc_cmd_t         cmd_o
);
  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          // a frozen step skips all queue updates
          state_d = status_i.frozen ? ST_COMMIT : ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        cmd_o.issue = 1'b1;
        state_d     = ST_WB0;
      end
      ST_WB0: begin
        cmd_o.wb0 = 1'b1;
        state_d   = ST_WB1;
      end
      ST_WB1: begin
        cmd_o.wb1 = 1'b1;
        state_d   = ST_READ;
      end
      ST_READ: begin
        cmd_o.read = 1'b1;
        state_d    = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

FILE: rtl/rbc_datapath.sv
// Datapath: slot memories, written marks, pointers and the commit decision.
`default_nettype none
module rbc_datapath import rbc_pkg::*; #(
  parameter int DEPTH = 32
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire in_item_t  in_data_i,
  input  wire rbc_cmd_t  cmd_i,
  output rbc_status_t    status_o,
  input  wire logic      out_ready_i,
  output logic           out_valid_o,
  output out_item_t      out_data_o
);
  localparam int PW = $clog2(DEPTH);
  typedef logic [PW-1:0] ptr_t;
  typedef logic [PW:0]   cnt_t;

  in_item_t         item_q;
  ptr_t             head_q, head_d, tail_q, tail_d;
  cnt_t             occ_q, occ_d;
  logic             flush_q, flush_d;
  logic [DEPTH-1:0] written_q;
  logic             out_valid_q;
  out_item_t        out_q, res;
  logic             clr_all, clr_head, taken;
  logic             issue_en, wb0_en, wb1_en;
  ptr_t             wb0_addr, wb1_addr, val_addr;
  logic [31:0]      val_wdata, val_rd;
  entry_t           ent_wdata, ent_rd;

  function automatic ptr_t ptr_inc(ptr_t p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Write enables for each step
  assign issue_en = cmd_i.issue && (item_q.issue_kind >= IK_REG) &&
                    (item_q.issue_kind <= IK_OTHER) && (occ_q < cnt_t'(DEPTH));
  assign wb0_en   = cmd_i.wb0 && item_q.wb0_valid && (32'(item_q.wb0_index) < DEPTH);
  assign wb1_en   = cmd_i.wb1 && item_q.wb1_valid && (32'(item_q.wb1_index) < DEPTH);
  assign wb0_addr = PW'(item_q.wb0_index);
  assign wb1_addr = PW'(item_q.wb1_index);

  assign ent_wdata = '{kind: item_q.issue_kind, dest: item_q.issue_dest,
                       pc: item_q.issue_pc, offset: item_q.issue_offset};

  // Value memory port mux: issue, then first, then second broadcast
  always_comb begin
    val_addr  = tail_q;
    val_wdata = item_q.issue_ready ? item_q.issue_offset : '0;
    if (cmd_i.wb0) begin
      val_addr  = wb0_addr;
      val_wdata = item_q.wb0_value;
    end else if (cmd_i.wb1) begin
      val_addr  = wb1_addr;
      val_wdata = item_q.wb1_value;
    end
  end

  rbc_ram #(.WIDTH($bits(entry_t)), .DEPTH(DEPTH)) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (issue_en),
    .waddr_i (tail_q),
    .wdata_i (ent_wdata),
    .re_i    (cmd_i.read),
    .raddr_i (head_q),
    .rdata_o (ent_rd)
  );

  rbc_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (issue_en || wb0_en || wb1_en),
    .waddr_i (val_addr),
    .wdata_i (val_wdata),
    .re_i    (cmd_i.read),
    .raddr_i (head_q),
    .rdata_o (val_rd)
  );

  // Commit decision on the head entry
  always_comb begin
    res      = '0;
    head_d   = head_q;
    tail_d   = tail_q;
    occ_d    = occ_q;
    flush_d  = flush_q;
    clr_all  = 1'b0;
    clr_head = 1'b0;
    taken    = (val_rd != '0);
    if (flush_q) begin
      flush_d = 1'b0;
    end else if (occ_q == '0) begin
      res.finish = item_q.terminate;
    end else if (written_q[head_q]) begin
      res.commit_valid = 1'b1;
      res.commit_index = 5'(head_q);
      clr_head         = 1'b1;
      head_d           = ptr_inc(head_q);
      occ_d            = occ_q - 1'b1;
      case (ent_rd.kind)
        IK_REG: begin
          res.commit_kind = CK_REG;
          res.commit_dest = ent_rd.dest;
          res.reg_value   = val_rd;
        end
        IK_STORE: res.commit_kind = CK_STORE;
        IK_BR_NT, IK_BR_T: begin
          res.commit_kind  = CK_BRANCH;
          res.branch_taken = taken;
          if (taken != (ent_rd.kind == IK_BR_T)) begin
            // mispredict: empty the queue and freeze one step
            res.redirect    = RD_FLUSH;
            res.redirect_pc = taken ? ent_rd.pc + ent_rd.offset : ent_rd.pc + PcStep;
            clr_all  = 1'b1;
            clr_head = 1'b0;
            head_d   = '0;
            tail_d   = '0;
            occ_d    = '0;
            flush_d  = 1'b1;
          end
        end
        IK_JALR: begin
          res.commit_kind = CK_JALR;
          res.commit_dest = ent_rd.dest;
          res.reg_value   = ent_rd.pc + PcStep;
          res.redirect    = RD_JALR;
          res.redirect_pc = val_rd;
        end
        default: res.commit_kind = CK_OTHER;
      endcase
    end
    res.full_res  = ({1'b0, occ_d} + 1'b1) >= (PW + 2)'(DEPTH);
    res.tail_slot = 5'(tail_d);
    res.head_slot = 5'(head_d);
  end

  // Item capture (payload)
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_data_i;
    end
  end

  // Queue control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      tail_q    <= '0;
      occ_q     <= '0;
      flush_q   <= 1'b0;
      written_q <= '0;
    end else begin
      if (issue_en) begin
        written_q[tail_q] <= item_q.issue_ready;
        tail_q            <= ptr_inc(tail_q);
        occ_q             <= occ_q + 1'b1;
      end
      if (wb0_en) begin
        written_q[wb0_addr] <= 1'b1;
      end
      if (wb1_en) begin
        written_q[wb1_addr] <= 1'b1;
      end
      if (cmd_i.commit) begin
        head_q  <= head_d;
        tail_q  <= tail_d;
        occ_q   <= occ_d;
        flush_q <= flush_d;
        if (clr_all) begin
          written_q <= '0;
        end else if (clr_head) begin
          written_q[head_q] <= 1'b0;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_q <= res;
    end
  end

  assign status_o.frozen   = flush_q;
  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_q;
endmodule
`default_nettype wire

FILE: rtl/reorder_buffer_commit.sv
// Top level: reorder buffer commit block.
// Each accepted item is one step of the reorder buffer: it appends the issued entry, applies
// both result broadcasts, then commits the head entry if it has been written, and yields one
// result carrying the commit and the queue status. A step runs through a sequencer that
// shares the write port of the value memory among the issue and the two broadcasts, then
// reads the head and commits; the frozen step after a mispredict goes straight to the
// commit. A new item is accepted only after the step before it has committed; a result
// that is not taken holds the commit of the next item.
// The next item is accepted while the previous result waits to be taken.
// Slot memories need no clearing after reset; written marks are flip-flops.
`default_nettype none
module reorder_buffer_commit import rbc_pkg::*; #(
  parameter int DEPTH = 32
) (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  rbc_in_if.sink    in_i,
  rbc_out_if.source out_o
);
  rbc_cmd_t    cmd;
  rbc_status_t status;

  rbc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rbc_datapath #(.DEPTH(DEPTH)) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_i.data),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_data_o  (out_o.data)
  );
endmodule
`default_nettype wire

FILE: rtl/rbc_checker.sv
// Checker: port-level properties of the commit results, bound to the top level.
`default_nettype none
module rbc_checker import rbc_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      out_valid_i,
  input wire logic      out_ready_i,
  input wire out_item_t out_data_i
);
  logic xfer;
  assign xfer = out_valid_i && out_ready_i;

  // No commit means all commit fields are quiet
  a_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && !out_data_i.commit_valid |-> out_data_i.commit_kind == CK_REG &&
      out_data_i.commit_dest == 5'd0 && out_data_i.reg_value == 32'sd0 &&
      out_data_i.commit_index == 5'd0 && !out_data_i.branch_taken &&
      out_data_i.redirect == RD_NONE && out_data_i.redirect_pc == 32'd0)
    else $error("commit fields set without a commit");

  // A flush comes from a branch and resets both pointers
  a_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && out_data_i.redirect == RD_FLUSH |-> out_data_i.commit_kind == CK_BRANCH &&
      out_data_i.head_slot == 5'd0 && out_data_i.tail_slot == 5'd0)
    else $error("flush without branch or pointers not reset");

  // Finish only with an empty queue
  a_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && out_data_i.finish |-> !out_data_i.commit_valid &&
      out_data_i.head_slot == out_data_i.tail_slot)
    else $error("finish with a nonempty queue");

  // Stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result changed while stalled");
endmodule

bind reorder_buffer_commit rbc_checker u_rbc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
`default_nettype wire
